/* rtl/keyboard_scancode_decoder_unit_defines.svh */
// Assertion macros shared by the keyboard scan-code decoder RTL.
`ifndef KEYBOARD_SCANCODE_DECODER_UNIT_DEFINES_SVH
`define KEYBOARD_SCANCODE_DECODER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KSD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/ksd_pkg.sv */
// Shared types, codes and helper functions of the keyboard scan-code decoder.
package ksd_pkg;

	localparam logic [2:0] FUNC_SCAN      = 3'd0;
	localparam logic [2:0] FUNC_POP       = 3'd1;
	localparam logic [2:0] FUNC_PEEK      = 3'd2;
	localparam logic [2:0] FUNC_CLR_DOWNS = 3'd3;
	localparam logic [2:0] FUNC_CLR_UPS   = 3'd4;
	localparam logic [2:0] FUNC_DOWN_TIME = 3'd5;
	localparam logic [2:0] FUNC_FLUSH     = 3'd6;
	localparam logic [2:0] FUNC_PUT       = 3'd7;

	localparam logic [7:0] BYTE_EXT         = 8'hE0;
	localparam logic [7:0] BYTE_PAUSE       = 8'hE1;
	localparam logic [7:0] BYTE_PAUSE_MAKE  = 8'h1D;
	localparam logic [7:0] BYTE_PAUSE_BREAK = 8'h9D;

	localparam logic [7:0] KEY_SHIFT_L  = 8'h2A;
	localparam logic [7:0] KEY_SHIFT_R  = 8'h36;
	localparam logic [7:0] KEY_ALT_L    = 8'h38;
	localparam logic [7:0] KEY_ALT_R    = 8'hB8;
	localparam logic [7:0] KEY_CTRL_L   = 8'h1D;
	localparam logic [7:0] KEY_CTRL_R   = 8'h9D;
	localparam logic [7:0] KEY_E1_SEQ   = 8'h61;
	localparam logic [7:0] KEY_NO_QUEUE = 8'hAA;

	localparam int unsigned NUM_KEYS = 256;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_FLUSH,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic sweep;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
	} status_t;

	// Flag order: left shift, right shift, left alt, right alt, left ctrl, right ctrl.
	function automatic logic [2:0] mods(input logic [5:0] f);
		mods = {f[5] | f[4], f[3] | f[2], f[1] | f[0]};
	endfunction

endpackage

/* rtl/ksd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ksd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/ksd_ctrl.sv */
// Controller state machine sequencing clear sweeps and word execution.
module ksd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             func_flush,
	input  ksd_pkg::status_t stat,
	output ksd_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	ksd_pkg::state_t state_q, state_d;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksd_pkg::ST_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.sweep   = 1'b0;
		cmd.exec    = 1'b0;
		busy        = 1'b1;
		unique case (state_q)
			ksd_pkg::ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ksd_pkg::ST_IDLE;
				end
			end
			ksd_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d = func_flush ? ksd_pkg::ST_FLUSH : ksd_pkg::ST_READ;
				end
			end
			ksd_pkg::ST_READ: begin
				state_d = ksd_pkg::ST_EXEC;
			end
			ksd_pkg::ST_FLUSH: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ksd_pkg::ST_EXEC;
				end
			end
			ksd_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ksd_pkg::ST_IDLE;
			end
			default: begin
				state_d = ksd_pkg::ST_INIT;
			end
		endcase
	end

	assign done = done_q;
endmodule

/* rtl/ksd_datapath.sv */
// Datapath: scan decoding, per-key statistics memory and the key queue.
module ksd_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int COUNT_BITS  = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ksd_pkg::cmd_t        cmd,
	output ksd_pkg::status_t     stat,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  logic [2:0]           func,
	input  logic [7:0]           scan_byte,
	input  logic [7:0]           key_index,
	input  logic [15:0]          put_code,
	input  logic signed [31:0]   now_time,
	output logic                 key_valid,
	output logic [15:0]          key_code,
	output logic signed [31:0]   key_time,
	output logic [15:0]          count_value,
	output logic signed [31:0]   down_time,
	output logic                 queue_not_empty,
	output logic [2:0]           modifier_status,
	output logic [7:0]           last_pressed_key,
	output logic [7:0]           last_released_key
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int T  = TIME_BITS;
	localparam int C  = COUNT_BITS;
	localparam int KW = 2 * T + 2 * C + 1;

	logic [2:0]     func_q;
	logic [7:0]     byte_q;
	logic [7:0]     key_q;
	logic [15:0]    put_q;
	logic [T-1:0]   now_q;
	logic           repeat_q;
	logic           prefix_q;
	logic [1:0]     pause_q;
	logic [7:0]     last_make_q;
	logic [7:0]     last_break_q;
	logic [QW-1:0]  head_q, tail_q;
	logic [5:0]     mod_q;
	logic [7:0]     sweep_cnt_q;

	logic           valid_q;
	logic [15:0]    code_q;
	logic [31:0]    ktime_q;
	logic [15:0]    cnt_q;
	logic [31:0]    dtime_q;

	logic           in_pause, op_valid, is_brk;
	logic [7:0]     dec_code, addr_sel;
	logic [5:0]     mod_nx, mod_hit;
	logic           key_pressed, key_op, enq, enq_with_time, enq_ok, pop;
	logic [15:0]    enq_code;
	logic [QW-1:0]  tail_next, head_next;
	logic [KW-1:0]  key_rdata, key_wdata;
	logic           key_we;
	logic           pr_r, pr_w;
	logic [T-1:0]   st_r, hd_r, st_w, hd_w;
	logic [C-1:0]   pc_r, rc_r, pc_w, rc_w;
	logic [15:0]    q_code_rd;
	logic [T-1:0]   q_time_rd;
	logic           qt_we;
	logic [QW-1:0]  qt_waddr;
	logic [T-1:0]   qt_wdata;
	logic [31:0]    cnt_ext;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			byte_q <= scan_byte;
			key_q  <= key_index;
			put_q  <= put_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (cmd.capture) begin
			now_q <= now_time[T-1:0];
		end
	end

	assign in_pause = (pause_q != 2'd0);
	assign op_valid = (byte_q != ksd_pkg::BYTE_EXT) &&
		(in_pause ? (byte_q == ksd_pkg::BYTE_PAUSE_MAKE ||
			byte_q == ksd_pkg::BYTE_PAUSE_BREAK) : (byte_q != ksd_pkg::BYTE_PAUSE));
	assign dec_code = in_pause ? ksd_pkg::KEY_E1_SEQ : {prefix_q, byte_q[6:0]};
	assign is_brk   = in_pause ? (byte_q == ksd_pkg::BYTE_PAUSE_BREAK) : byte_q[7];
	assign addr_sel = (func_q == ksd_pkg::FUNC_SCAN) ? dec_code : key_q;

	assign {pr_r, st_r, hd_r, pc_r, rc_r} = key_rdata;
	assign key_pressed = pr_r;

	assign mod_hit = {dec_code == ksd_pkg::KEY_CTRL_R, dec_code == ksd_pkg::KEY_CTRL_L,
		dec_code == ksd_pkg::KEY_ALT_R, dec_code == ksd_pkg::KEY_ALT_L,
		dec_code == ksd_pkg::KEY_SHIFT_R, dec_code == ksd_pkg::KEY_SHIFT_L};

	assign tail_next = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_next = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		mod_nx        = mod_q;
		key_op        = 1'b0;
		pr_w          = pr_r;
		st_w          = st_r;
		hd_w          = hd_r;
		pc_w          = pc_r;
		rc_w          = rc_r;
		enq           = 1'b0;
		enq_with_time = 1'b0;
		enq_code      = put_q;
		pop           = 1'b0;
		unique case (func_q)
			ksd_pkg::FUNC_SCAN: begin
				if (op_valid) begin
					key_op = 1'b1;
					pr_w   = !is_brk;
					mod_nx = is_brk ? (mod_q & ~mod_hit) : (mod_q | mod_hit);
					if (is_brk) begin
						if (rc_r != '1) begin
							rc_w = rc_r + 1'b1;
						end
						hd_w = hd_r + (now_q - st_r);
					end else begin
						if (!key_pressed) begin
							st_w = now_q;
							if (pc_r != '1) begin
								pc_w = pc_r + 1'b1;
							end
						end
						enq = (!key_pressed || repeat_q) &&
							(dec_code != ksd_pkg::KEY_NO_QUEUE);
						enq_with_time = 1'b1;
					end
				end
				enq_code = {5'd0, ksd_pkg::mods(mod_nx), dec_code};
			end
			ksd_pkg::FUNC_POP: begin
				pop = (head_q != tail_q);
			end
			ksd_pkg::FUNC_CLR_DOWNS: begin
				key_op = 1'b1;
				pc_w   = '0;
			end
			ksd_pkg::FUNC_CLR_UPS: begin
				key_op = 1'b1;
				rc_w   = '0;
			end
			ksd_pkg::FUNC_DOWN_TIME: begin
				key_op = 1'b1;
				if (key_pressed) begin
					st_w = now_q;
				end else begin
					hd_w = '0;
				end
			end
			ksd_pkg::FUNC_PUT: begin
				enq = 1'b1;
			end
			default: begin
				enq = 1'b0;
			end
		endcase
	end

	assign enq_ok    = cmd.exec && enq && (tail_next != head_q);
	assign key_we    = cmd.sweep || (cmd.exec && key_op);
	assign key_wdata = cmd.sweep ? {1'b0, now_q, {(T + 2 * C){1'b0}}} :
		{pr_w, st_w, hd_w, pc_w, rc_w};

	ksd_ram #(.WIDTH(KW), .DEPTH(ksd_pkg::NUM_KEYS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (cmd.sweep ? sweep_cnt_q : addr_sel),
		.wdata (key_wdata),
		.raddr (addr_sel),
		.rdata (key_rdata)
	);

	ksd_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_code_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr (tail_q),
		.wdata (enq_code),
		.raddr (head_q),
		.rdata (q_code_rd)
	);

	assign qt_we    = (cmd.sweep && ({1'b0, sweep_cnt_q} < 9'(QUEUE_DEPTH))) ||
		(enq_ok && enq_with_time);
	assign qt_waddr = cmd.sweep ? sweep_cnt_q[QW-1:0] : tail_q;
	assign qt_wdata = cmd.sweep ? '0 : now_q;

	ksd_ram #(.WIDTH(T), .DEPTH(QUEUE_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (qt_we),
		.waddr (qt_waddr),
		.wdata (qt_wdata),
		.raddr (head_q),
		.rdata (q_time_rd)
	);

	assign stat.sweep_last = (sweep_cnt_q == 8'hFF);
	assign cnt_ext = 32'((func_q == ksd_pkg::FUNC_CLR_DOWNS) ? pc_r : rc_r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q     <= 1'b1;
			prefix_q     <= 1'b0;
			pause_q      <= 2'd0;
			last_make_q  <= '0;
			last_break_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			mod_q        <= '0;
			sweep_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				repeat_q <= cfg_data;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
				mod_q       <= '0;
				head_q      <= '0;
				tail_q      <= '0;
			end else if (cmd.exec) begin
				mod_q <= mod_nx;
				if (pop) begin
					head_q <= head_next;
				end
				if (enq_ok) begin
					tail_q <= tail_next;
				end
				if (func_q == ksd_pkg::FUNC_SCAN) begin
					if (byte_q == ksd_pkg::BYTE_EXT) begin
						prefix_q <= 1'b1;
					end else if (in_pause) begin
						pause_q <= pause_q - 2'd1;
						if (op_valid) begin
							prefix_q <= 1'b0;
						end
					end else if (byte_q == ksd_pkg::BYTE_PAUSE) begin
						pause_q <= 2'd2;
					end else begin
						prefix_q <= 1'b0;
					end
					if (op_valid) begin
						if (is_brk) begin
							last_break_q <= dec_code;
						end else begin
							last_make_q <= dec_code;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			valid_q <= 1'b0;
			code_q  <= '0;
			ktime_q <= '0;
			cnt_q   <= '0;
			dtime_q <= '0;
			case (func_q) inside
				ksd_pkg::FUNC_POP, ksd_pkg::FUNC_PEEK: begin
					if (head_q != tail_q) begin
						valid_q <= 1'b1;
						code_q  <= q_code_rd;
						ktime_q <= 32'($signed(q_time_rd));
					end
				end
				ksd_pkg::FUNC_CLR_DOWNS, ksd_pkg::FUNC_CLR_UPS: begin
					cnt_q <= cnt_ext[15:0];
				end
				ksd_pkg::FUNC_DOWN_TIME: begin
					dtime_q <= key_pressed ? 32'($signed(T'(now_q - st_r))) :
						32'($signed(hd_r));
				end
				default: begin
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign key_valid         = valid_q;
	assign key_code          = code_q;
	assign key_time          = ktime_q;
	assign count_value       = cnt_q;
	assign down_time         = dtime_q;
	assign queue_not_empty   = (head_q != tail_q);
	assign modifier_status   = ksd_pkg::mods(mod_q);
	assign last_pressed_key  = last_make_q;
	assign last_released_key = last_break_q;
endmodule

/* rtl/keyboard_scancode_decoder_unit.sv */
// Top level of the set-1 keyboard scan-code decoder with key queue and statistics.
// A word accepted on start passes the read and execute states before done answers it;
// no new word is taken until then, while per-key statistics are read and written back.
// A flush word sweeps all 256 key entries, then executes and gives its done pulse.
// After reset the same sweep clears all 256 key entries with busy high before any word.
`include "keyboard_scancode_decoder_unit_defines.svh"
module keyboard_scancode_decoder_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int COUNT_BITS  = 16,
	parameter int TIME_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [2:0]         func,
	input  logic [7:0]         scan_byte,
	input  logic [7:0]         key_index,
	input  logic [15:0]        put_code,
	input  logic signed [31:0] now_time,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	output logic               key_valid,
	output logic [15:0]        key_code,
	output logic signed [31:0] key_time,
	output logic [15:0]        count_value,
	output logic signed [31:0] down_time,
	output logic               queue_not_empty,
	output logic [2:0]         modifier_status,
	output logic [7:0]         last_pressed_key,
	output logic [7:0]         last_released_key
);
	ksd_pkg::cmd_t    cmd;
	ksd_pkg::status_t stat;
	logic             accept;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	ksd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func_flush (func == ksd_pkg::FUNC_FLUSH),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	ksd_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.COUNT_BITS  (COUNT_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (cfg_data),
		.func              (func),
		.scan_byte         (scan_byte),
		.key_index         (key_index),
		.put_code          (put_code),
		.now_time          (now_time),
		.key_valid         (key_valid),
		.key_code          (key_code),
		.key_time          (key_time),
		.count_value       (count_value),
		.down_time         (down_time),
		.queue_not_empty   (queue_not_empty),
		.modifier_status   (modifier_status),
		.last_pressed_key  (last_pressed_key),
		.last_released_key (last_released_key)
	);

	`KSD_ASSERT_NEXT(a_accept_busy, accept, busy)
	`KSD_ASSERT_SAME(a_done_after_exec, done, $past(cmd.exec))
	`KSD_ASSERT_SAME(a_sweep_exclusive, cmd.sweep, !cmd.exec && busy)
endmodule

/* test/tb_keyboard_scancode_decoder_unit.sv */
// Self-checking testbench for the keyboard scan-code decoder with key queue and statistics.
module tb_keyboard_scancode_decoder_unit;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [2:0]         fn;
		logic [7:0]         sbyte;
		logic [7:0]         kidx;
		logic [15:0]        pcode;
		logic signed [31:0] tnow;
	} word_t;

	typedef struct {
		logic               kvalid;
		logic [15:0]        kcode;
		logic [31:0]        ktime;
		logic [15:0]        cnt;
		logic [31:0]        dtime;
		logic               qne;
		logic [2:0]         mods;
		logic [7:0]         lmake;
		logic [7:0]         lbreak;
	} answer_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic [2:0]         func;
	logic [7:0]         scan_byte;
	logic [7:0]         key_index;
	logic [15:0]        put_code;
	logic signed [31:0] now_time;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;
	logic               key_valid;
	logic [15:0]        key_code;
	logic signed [31:0] key_time;
	logic [15:0]        count_value;
	logic signed [31:0] down_time;
	logic               queue_not_empty;
	logic [2:0]         modifier_status;
	logic [7:0]         last_pressed_key;
	logic [7:0]         last_released_key;

	keyboard_scancode_decoder_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.func(func), .scan_byte(scan_byte), .key_index(key_index), .put_code(put_code),
		.now_time(now_time), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .key_valid(key_valid), .key_code(key_code),
		.key_time(key_time), .count_value(count_value), .down_time(down_time),
		.queue_not_empty(queue_not_empty), .modifier_status(modifier_status),
		.last_pressed_key(last_pressed_key), .last_released_key(last_released_key)
	);

	word_t   pending_words[$];
	answer_t expected_answers[$];
	word_t   cur_word;
	int      sender_idle_pct;
	int      mismatches;
	int      cycles;
	bit      cfg_pending;
	bit      cfg_value;
	logic [31:0] sim_clock;

	// Mirror of the decoder state.
	bit          m_repeat;
	bit          m_pressed[256];
	logic [31:0] m_start_t[256];
	logic [31:0] m_held[256];
	logic [15:0] m_downs[256];
	logic [15:0] m_ups[256];
	logic [15:0] m_qcode[16];
	logic [31:0] m_qtime[16];
	logic [3:0]  m_head;
	logic [3:0]  m_tail;
	bit          m_ext;
	int          m_pause_left;
	logic [7:0]  m_last_make;
	logic [7:0]  m_last_break;

	logic [7:0] key_pool[12] = '{8'h1E, 8'h10, 8'h2A, 8'h36, 8'h38, 8'h1D, 8'h45, 8'h01,
		8'h7F, 8'h2C, 8'h61, 8'h00};

	function automatic logic [2:0] held_modifiers();
		held_modifiers = {m_pressed[ksd_pkg::KEY_CTRL_L] | m_pressed[ksd_pkg::KEY_CTRL_R],
			m_pressed[ksd_pkg::KEY_ALT_L] | m_pressed[ksd_pkg::KEY_ALT_R],
			m_pressed[ksd_pkg::KEY_SHIFT_L] | m_pressed[ksd_pkg::KEY_SHIFT_R]};
	endfunction

	function automatic void queue_key(logic [15:0] code, bit with_time, logic [31:0] t);
		logic [3:0] nxt;
		nxt = m_tail + 4'd1;
		if (nxt != m_head) begin
			m_qcode[m_tail] = code;
			if (with_time)
				m_qtime[m_tail] = t;
			m_tail = nxt;
		end
	endfunction

	function automatic answer_t decode_word(word_t w);
		answer_t    r;
		logic [7:0] code;
		logic [7:0] b;
		logic [31:0] now;
		bit         brk;
		bit         go;
		bit         qit;
		r = '{default: '0};
		b = w.sbyte;
		now = w.tnow;
		code = '0;
		brk = 0;
		go = 1;
		case (w.fn)
			ksd_pkg::FUNC_SCAN: begin
				if (b == ksd_pkg::BYTE_EXT) begin
					m_ext = 1;
					go = 0;
				end else if (m_pause_left > 0) begin
					m_pause_left--;
					if (b == ksd_pkg::BYTE_PAUSE_MAKE)
						code = ksd_pkg::KEY_E1_SEQ;
					else if (b == ksd_pkg::BYTE_PAUSE_BREAK) begin
						code = ksd_pkg::KEY_E1_SEQ;
						brk = 1;
					end else
						go = 0;
				end else if (b == ksd_pkg::BYTE_PAUSE) begin
					m_pause_left = 2;
					go = 0;
				end else begin
					brk = b[7];
					code = {m_ext, b[6:0]};
				end
				if (go) begin
					m_ext = 0;
					if (brk) begin
						m_last_break = code;
						m_pressed[code] = 0;
						if (m_ups[code] != 16'hFFFF)
							m_ups[code]++;
						m_held[code] = m_held[code] + (now - m_start_t[code]);
					end else begin
						qit = 1;
						m_last_make = code;
						if (!m_pressed[code]) begin
							m_start_t[code] = now;
							m_pressed[code] = 1;
							if (m_downs[code] != 16'hFFFF)
								m_downs[code]++;
						end else if (!m_repeat)
							qit = 0;
						if (code == ksd_pkg::KEY_NO_QUEUE)
							qit = 0;
						if (qit)
							queue_key({5'd0, held_modifiers(), code}, 1, now);
					end
				end
			end
			ksd_pkg::FUNC_POP, ksd_pkg::FUNC_PEEK: begin
				if (m_head != m_tail) begin
					r.kvalid = 1;
					r.kcode = m_qcode[m_head];
					r.ktime = m_qtime[m_head];
					if (w.fn == ksd_pkg::FUNC_POP)
						m_head++;
				end
			end
			ksd_pkg::FUNC_CLR_DOWNS: begin
				r.cnt = m_downs[w.kidx];
				m_downs[w.kidx] = 0;
			end
			ksd_pkg::FUNC_CLR_UPS: begin
				r.cnt = m_ups[w.kidx];
				m_ups[w.kidx] = 0;
			end
			ksd_pkg::FUNC_DOWN_TIME: begin
				if (!m_pressed[w.kidx]) begin
					r.dtime = m_held[w.kidx];
					m_held[w.kidx] = 0;
				end else begin
					r.dtime = now - m_start_t[w.kidx];
					m_start_t[w.kidx] = now;
				end
			end
			ksd_pkg::FUNC_FLUSH: begin
				m_head = 0;
				m_tail = 0;
				for (int i = 0; i < 16; i++) begin
					m_qcode[i] = '0;
					m_qtime[i] = '0;
				end
				for (int i = 0; i < 256; i++) begin
					m_pressed[i] = 0;
					m_start_t[i] = now;
					m_held[i] = '0;
					m_downs[i] = '0;
					m_ups[i] = '0;
				end
			end
			default: queue_key(w.pcode, 0, '0);
		endcase
		r.qne = (m_head != m_tail);
		r.mods = held_modifiers();
		r.lmake = m_last_make;
		r.lbreak = m_last_break;
		return r;
	endfunction

	task automatic add_word(logic [2:0] fn, logic [7:0] b, logic [7:0] k, logic [15:0] pc);
		word_t w;
		if ($urandom_range(99) < 5)
			sim_clock = $urandom;
		else
			sim_clock = sim_clock + $urandom_range(1, 5000);
		w.fn = fn;
		w.sbyte = b;
		w.kidx = k;
		w.pcode = pc;
		w.tnow = sim_clock;
		pending_words.push_back(w);
	endtask

	function automatic logic [7:0] pick_key();
		logic [7:0] k;
		k = key_pool[$urandom_range(11)];
		if ($urandom_range(99) < 30)
			k[7] = 1;
		if ($urandom_range(99) < 15)
			k = 8'($urandom);
		return k;
	endfunction

	task automatic add_random_words(int n);
		int  r;
		logic [7:0] k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				k = key_pool[$urandom_range(11)];
				if ($urandom_range(99) < 30)
					add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_EXT, '0, '0);
				add_word(ksd_pkg::FUNC_SCAN,
					{($urandom_range(99) < 40) ? 1'b1 : 1'b0, k[6:0]}, '0, '0);
			end else if (r < 45) begin
				add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_PAUSE, '0, '0);
				add_word(ksd_pkg::FUNC_SCAN, $urandom_range(1) ?
					ksd_pkg::BYTE_PAUSE_MAKE : ksd_pkg::BYTE_PAUSE_BREAK, '0, '0);
				if ($urandom_range(1))
					add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_EXT, '0, '0);
				add_word(ksd_pkg::FUNC_SCAN, 8'($urandom), '0, '0);
			end else if (r < 50)
				add_word(ksd_pkg::FUNC_SCAN, 8'($urandom), 8'($urandom), 16'($urandom));
			else if (r < 62)
				add_word(ksd_pkg::FUNC_POP, 8'($urandom), 8'($urandom), 16'($urandom));
			else if (r < 68)
				add_word(ksd_pkg::FUNC_PEEK, '0, '0, '0);
			else if (r < 79)
				add_word(ksd_pkg::FUNC_PUT, '0, '0, 16'($urandom));
			else if (r < 85)
				add_word(ksd_pkg::FUNC_CLR_DOWNS, '0, pick_key(), '0);
			else if (r < 90)
				add_word(ksd_pkg::FUNC_CLR_UPS, '0, pick_key(), '0);
			else if (r < 98)
				add_word(ksd_pkg::FUNC_DOWN_TIME, '0, pick_key(), '0);
			else
				add_word(ksd_pkg::FUNC_FLUSH, '0, '0, '0);
		end
	endtask

	task automatic add_directed_words();
		add_word(ksd_pkg::FUNC_POP, '0, '0, '0);
		add_word(ksd_pkg::FUNC_PEEK, '0, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h2A, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h1E, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h1E, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_EXT, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h38, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_EXT, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h2A, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h9E, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h90, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_PAUSE, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_PAUSE_MAKE, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'h45, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_PAUSE, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_EXT, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, ksd_pkg::BYTE_PAUSE_BREAK, '0, '0);
		add_word(ksd_pkg::FUNC_SCAN, 8'hC5, '0, '0);
		add_word(ksd_pkg::FUNC_PEEK, '0, '0, '0);
		add_word(ksd_pkg::FUNC_POP, '0, '0, '0);
		add_word(ksd_pkg::FUNC_CLR_DOWNS, '0, 8'h1E, '0);
		add_word(ksd_pkg::FUNC_CLR_UPS, '0, 8'h1E, '0);
		add_word(ksd_pkg::FUNC_DOWN_TIME, '0, 8'h1E, '0);
		add_word(ksd_pkg::FUNC_DOWN_TIME, '0, 8'hB8, '0);
		for (int i = 0; i < 16; i++)
			add_word(ksd_pkg::FUNC_PUT, '0, '0, (i % 2) ? 16'hFFFF : 16'h0000);
		add_word(ksd_pkg::FUNC_SCAN, 8'h10, '0, '0);
		pending_words[$].tnow = 32'h7FFFFFFF;
		add_word(ksd_pkg::FUNC_DOWN_TIME, '0, 8'h10, '0);
		pending_words[$].tnow = 32'h80000000;
		add_word(ksd_pkg::FUNC_FLUSH, '0, '0, '0);
		add_word(ksd_pkg::FUNC_POP, '0, '0, '0);
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && expected_answers.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_repeat(bit v);
		cfg_value = v;
		cfg_pending = 1;
		wait (!cfg_pending);
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Driver: presents config writes and pending words and mirrors each accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				m_repeat = cfg_data;
				cfg_valid <= 0;
				cfg_pending = 0;
			end else if (cfg_pending && !cfg_valid) begin
				cfg_valid <= 1;
				cfg_data <= cfg_value;
			end
			if (start && !busy)
				expected_answers.push_back(decode_word(cur_word));
			if (!start || !busy) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					cur_word = pending_words.pop_front();
					start <= 1;
					func <= cur_word.fn;
					scan_byte <= cur_word.sbyte;
					key_index <= cur_word.kidx;
					put_code <= cur_word.pcode;
					now_time <= cur_word.tnow;
				end else
					start <= 0;
			end
		end
	end

	// Monitor: checks each result word against the oldest expectation.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word, key_code %h", key_code);
			end else begin
				e = expected_answers.pop_front();
				if (e.kvalid !== key_valid || e.kcode !== key_code || e.ktime !== key_time ||
					e.cnt !== count_value || e.dtime !== down_time ||
					e.qne !== queue_not_empty || e.mods !== modifier_status ||
					e.lmake !== last_pressed_key || e.lbreak !== last_released_key) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp %b %h %h %h %h %b %h %h %h",
							" got %b %h %h %h %h %b %h %h %h"},
							e.kvalid, e.kcode, e.ktime, e.cnt, e.dtime, e.qne, e.mods,
							e.lmake, e.lbreak, key_valid, key_code, key_time, count_value,
							down_time, queue_not_empty, modifier_status, last_pressed_key,
							last_released_key);
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		start = 0;
		func = ksd_pkg::FUNC_SCAN;
		scan_byte = 0;
		key_index = 0;
		put_code = 0;
		now_time = 0;
		cfg_valid = 0;
		cfg_data = 0;
		cfg_pending = 0;
		cycles = 0;
		mismatches = 0;
		sim_clock = 0;
		sender_idle_pct = 6;
		m_repeat = 1;
		for (int i = 0; i < 256; i++) begin
			m_pressed[i] = 0;
			m_start_t[i] = '0;
			m_held[i] = '0;
			m_downs[i] = '0;
			m_ups[i] = '0;
		end
		for (int i = 0; i < 16; i++) begin
			m_qcode[i] = '0;
			m_qtime[i] = '0;
		end
		m_head = 0;
		m_tail = 0;
		m_ext = 0;
		m_pause_left = 0;
		m_last_make = 0;
		m_last_break = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		write_repeat(1);
		add_directed_words();
		add_random_words(162);
		drain();
		write_repeat(0);
		sender_idle_pct = 55;
		add_random_words(162);
		drain();
		write_repeat(1);
		sender_idle_pct = 0;
		add_random_words(162);
		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
